/* src/bpm_pkg.sv */
package bpm_pkg;

    localparam int unsigned POOL_ENTRIES_DEF = 16;
    localparam int unsigned REG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] MIN_SIZE_RST = 32'd65536;
    localparam logic [31:0] MAX_AGE_RST  = 32'd1000;

    typedef enum logic [2:0] {
        OP_ACQUIRE = 3'd0,
        OP_RELEASE = 3'd1,
        OP_COLLECT = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_REUSED     = 4'd0,
        ST_CREATED    = 4'd1,
        ST_EXHAUSTED  = 4'd2,
        ST_CREATE_ERR = 4'd3,
        ST_RELEASED   = 4'd4,
        ST_UNKNOWN_ID = 4'd5,
        ST_COLLECTED  = 4'd6,
        ST_CLEARED    = 4'd7,
        ST_TICKED     = 4'd8
    } status_t;

    localparam logic REG_MIN_SIZE = 1'b0;
    localparam logic REG_MAX_AGE  = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] req_size;
        logic [15:0] buf_id;
        logic        alloc_ok;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] granted_id;
        logic [31:0] granted_size;
        logic [4:0]  removed_count;
    } out_item_t;

    typedef struct packed {
        logic        in_use;
        logic [31:0] size;
        logic [31:0] last_used;
        logic [15:0] ident;
    } slot_t;

endpackage

/* src/buffer_pool_manager.sv */
// Buffer pool manager. Keeps an ordered table of up to POOL_ENTRIES buffers
// (id, size, in-use flag, last-used time) and answers acquire, release,
// collect, clear and tick items with exactly one result item each; items with
// an undefined op are taken and dropped. One sequencer walks the table one
// entry per cycle with a single shared compare unit. The steps from the
// accepting edge to the result being valid:
//   - acquire that reuses an entry: first-fit pass, then load;
//   - acquire that appends to a table with room: search, decide, create, load;
//   - acquire on a full table: the search, an in-place compaction pass for
//     the age rule and a decide step; if still full, a minimum-size pass (load
//     if exhausted) and a shift pass to close the gap; then create and load;
//   - release and collect: a search or compaction pass, then load;
//   - clear and tick: no pass, only the load.
// The result register is also the working register, so the block takes no new
// item until the previous result has been taken; it is ready again in the
// cycle after the result is loaded, provided the output register is free.
// The user must write min_size and max_age through the plain configuration
// port only while the block is idle; the block itself does not enforce this.
module buffer_pool_manager #(
    parameter int unsigned POOL_ENTRIES = bpm_pkg::POOL_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bpm_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bpm_pkg::out_item_t                 m_data,
    input  logic                               cfg_we,
    input  logic [bpm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bpm_pkg::*;

    localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_PURGE = 9'b000000100,
        S_MIN   = 9'b000001000,
        S_SHIFT = 9'b000010000,
        S_DECIDE= 9'b000100000,
        S_CREATE= 9'b001000000,
        S_DONE  = 9'b010000000,
        S_REL   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    slot_t tbl_reg [POOL_ENTRIES];
    slot_t tbl_next [POOL_ENTRIES];

    logic [31:0] min_size_reg, max_age_reg, time_reg, time_next;
    logic [15:0] nid_reg, nid_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    in_item_t item_reg, item_next;
    logic [31:0] need_reg, need_next;
    logic [IW-1:0] rd_reg, rd_next, wr_reg, wr_next, best_reg, best_next;
    logic found_reg, found_next;
    logic [4:0] rem_reg, rem_next;
    out_item_t res_reg, res_next;
    logic m_valid_reg, m_valid_next;

    // shared compare unit
    slot_t cur;
    logic [31:0] age;
    logic old_hit, fit_hit, smaller;
    logic rd_last;

    assign cur     = tbl_reg[rd_reg];
    assign age     = time_reg - cur.last_used;
    assign old_hit = !cur.in_use && (age > max_age_reg);
    assign fit_hit = !cur.in_use && (cur.size >= need_reg);
    assign smaller = !cur.in_use && (!found_reg || cur.size < tbl_reg[best_reg].size);
    assign rd_last = (CW'(rd_reg) + CW'(1)) >= cnt_reg;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    function automatic logic [4:0] inc_sat(input logic [4:0] v);
        return (v == 5'd31) ? v : v + 5'd1;
    endfunction

    always_comb begin
        state_next   = state_reg;
        tbl_next     = tbl_reg;
        time_next    = time_reg;
        nid_next     = nid_reg;
        cnt_next     = cnt_reg;
        item_next    = item_reg;
        need_next    = need_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        rem_next     = rem_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    need_next = (s_data.req_size < min_size_reg) ? min_size_reg
                                                                  : s_data.req_size;
                    rd_next   = '0;
                    wr_next   = '0;
                    rem_next  = '0;
                    found_next = 1'b0;
                    res_next  = '0;
                    unique case (s_data.op)
                        OP_ACQUIRE: state_next = (cnt_reg == '0) ? S_DECIDE : S_SCAN;
                        OP_RELEASE: begin
                            res_next.status = ST_UNKNOWN_ID;
                            state_next = (cnt_reg == '0) ? S_DONE : S_REL;
                        end
                        OP_COLLECT: begin
                            res_next.status = ST_COLLECTED;
                            state_next = (cnt_reg == '0) ? S_DONE : S_PURGE;
                        end
                        OP_CLEAR: begin
                            res_next.status = ST_CLEARED;
                            rem_next = 5'(cnt_reg);
                            for (int i = 0; i < POOL_ENTRIES; i++) begin
                                tbl_next[i].in_use = 1'b0;
                            end
                            cnt_next = '0;
                            state_next = S_DONE;
                        end
                        OP_TICK: begin
                            res_next.status = ST_TICKED;
                            time_next = time_reg + 32'd1;
                            state_next = S_DONE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (fit_hit) begin
                    tbl_next[rd_reg].in_use    = 1'b1;
                    tbl_next[rd_reg].last_used = time_reg;
                    res_next.status       = ST_REUSED;
                    res_next.granted_id   = cur.ident;
                    res_next.granted_size = cur.size;
                    state_next = S_DONE;
                end else if (rd_last) begin
                    rd_next = '0;
                    wr_next = '0;
                    state_next = (cnt_reg == CW'(POOL_ENTRIES)) ? S_PURGE : S_DECIDE;
                end else begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            S_PURGE: begin
                // in-place compaction: keep entries, copy down over dropped ones
                if (old_hit) begin
                    rem_next = inc_sat(rem_reg);
                end else begin
                    tbl_next[wr_reg] = cur;
                    wr_next = wr_reg + 1'b1;
                end
                if (rd_last) begin
                    cnt_next = old_hit ? CW'(wr_reg) : CW'({1'b0, wr_reg} + 1'b1);
                    for (int i = 0; i < POOL_ENTRIES; i++) begin
                        if (CW'(i) >= (old_hit ? CW'(wr_reg) : CW'({1'b0, wr_reg} + 1'b1)))
                            tbl_next[i].in_use = 1'b0;
                    end
                    rd_next = '0;
                    found_next = 1'b0;
                    if (item_reg.op == OP_COLLECT) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end else begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                rd_next = '0;
                found_next = 1'b0;
                if (cnt_reg == CW'(POOL_ENTRIES)) begin
                    state_next = S_MIN;
                end else begin
                    state_next = S_CREATE;
                end
            end
            S_MIN: begin
                if (smaller) begin
                    best_next = rd_reg;
                    found_next = 1'b1;
                end
                if (rd_last) begin
                    // evict only a free entry smaller than the raised request
                    if (!(found_reg || smaller) ||
                        (smaller ? cur.size : tbl_reg[best_reg].size) >= need_reg) begin
                        res_next.status = ST_EXHAUSTED;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                // close the gap one entry per cycle
                if ((CW'(best_reg) + CW'(1)) < cnt_reg) begin
                    tbl_next[best_reg] = tbl_reg[best_reg + 1'b1];
                    best_next = best_reg + 1'b1;
                end else begin
                    tbl_next[best_reg].in_use = 1'b0;
                    cnt_next = cnt_reg - 1'b1;
                    rem_next = inc_sat(rem_reg);
                    state_next = S_CREATE;
                end
            end
            S_CREATE: begin
                if (!item_reg.alloc_ok) begin
                    res_next.status = ST_CREATE_ERR;
                end else begin
                    tbl_next[cnt_reg[IW-1:0]].in_use    = 1'b1;
                    tbl_next[cnt_reg[IW-1:0]].size      = need_reg;
                    tbl_next[cnt_reg[IW-1:0]].last_used = time_reg;
                    tbl_next[cnt_reg[IW-1:0]].ident     = nid_reg;
                    cnt_next = cnt_reg + 1'b1;
                    res_next.status       = ST_CREATED;
                    res_next.granted_id   = nid_reg;
                    res_next.granted_size = need_reg;
                    nid_next = nid_reg + 16'd1;
                end
                state_next = S_DONE;
            end
            S_REL: begin
                if (cur.ident == item_reg.buf_id) begin
                    tbl_next[rd_reg].in_use    = 1'b0;
                    tbl_next[rd_reg].last_used = time_reg;
                    res_next.status = ST_RELEASED;
                    state_next = S_DONE;
                end else if (rd_last) begin
                    state_next = S_DONE;
                end else begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    res_next.removed_count = rem_reg;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            time_reg     <= '0;
            nid_reg      <= '0;
            min_size_reg <= MIN_SIZE_RST;
            max_age_reg  <= MAX_AGE_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            time_reg    <= time_next;
            nid_reg     <= nid_next;
            if (cfg_we) begin
                if (cfg_index == REG_MIN_SIZE) min_size_reg <= cfg_data;
                else                           max_age_reg  <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            if (!aresetn) tbl_reg[i].in_use <= 1'b0;
            else          tbl_reg[i].in_use <= tbl_next[i].in_use;
            tbl_reg[i].size      <= tbl_next[i].size;
            tbl_reg[i].last_used <= tbl_next[i].last_used;
            tbl_reg[i].ident     <= tbl_next[i].ident;
        end
        item_reg  <= item_next;
        need_reg  <= need_next;
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(POOL_ENTRIES))
        else $error("entry count above pool size");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed while stalled");

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpm_pkg::*;

    localparam int unsigned SLOTS       = POOL_ENTRIES_DEF;
    // room for the slowest acquire, with a generous margin
    localparam int unsigned SETTLE_CYC  = 4 * SLOTS + 40;
    localparam int unsigned HOLD_CYC    = 300;
    localparam int unsigned WDOG_LIMIT  = 4000;
    localparam int unsigned RAND_PER_PH = 150;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    buffer_pool_manager i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Shadow pool: own copy of table, time, id counter and registers
    // ---------------------------------------------------------------------
    logic [31:0] sh_min_size;
    logic [31:0] sh_max_age;
    logic        pool_busy  [SLOTS];
    logic [31:0] pool_size  [SLOTS];
    logic [31:0] pool_stamp [SLOTS];
    logic [15:0] pool_ident [SLOTS];
    int unsigned pool_count;
    logic [31:0] pool_clock;
    logic [15:0] pool_next_id;

    out_item_t   pending_results[$];
    int unsigned error_count;

    // control between stimulus and the receiver process
    bit quiet;        // no idling in the last part
    bit hold_request; // ask the receiver for one long hold-off

    function automatic void shadow_reset();
        sh_min_size  = MIN_SIZE_RST;
        sh_max_age   = MAX_AGE_RST;
        for (int k = 0; k < SLOTS; k++) begin
            pool_busy[k]  = 1'b0;
            pool_size[k]  = '0;
            pool_stamp[k] = '0;
            pool_ident[k] = '0;
        end
        pool_count   = 0;
        pool_clock   = '0;
        pool_next_id = '0;
    endfunction

    // remove one entry, closing the gap so table order is kept
    function automatic void drop_slot(int unsigned idx);
        for (int unsigned k = idx; k + 1 < pool_count; k++) begin
            pool_busy[k]  = pool_busy[k+1];
            pool_size[k]  = pool_size[k+1];
            pool_stamp[k] = pool_stamp[k+1];
            pool_ident[k] = pool_ident[k+1];
        end
        pool_count--;
        pool_busy[pool_count] = 1'b0;
    endfunction

    // age rule: free entries idle for more than max_age go (mod 2^32 age)
    function automatic int unsigned purge_aged();
        int unsigned k;
        int unsigned n;
        logic [31:0] age;
        k = 0;
        n = 0;
        while (k < pool_count) begin
            age = pool_clock - pool_stamp[k];
            if (!pool_busy[k] && age > sh_max_age) begin
                drop_slot(k);
                n++;
            end else begin
                k++;
            end
        end
        return n;
    endfunction

    // next result of the pool for one item; 0 when the item yields nothing
    function automatic bit pool_predict(input in_item_t it, output out_item_t res);
        bit          done;
        bit          found;
        int unsigned best;
        int unsigned removed;
        logic [31:0] need;
        res     = '0;
        removed = 0;
        if (it.op > OP_TICK) return 1'b0;
        case (it.op)
            OP_ACQUIRE: begin
                done = 1'b0;
                need = (it.req_size < sh_min_size) ? sh_min_size : it.req_size;
                for (int unsigned k = 0; k < pool_count && !done; k++) begin
                    if (!pool_busy[k] && pool_size[k] >= need) begin
                        pool_busy[k]     = 1'b1;
                        pool_stamp[k]    = pool_clock;
                        res.status       = ST_REUSED;
                        res.granted_id   = pool_ident[k];
                        res.granted_size = pool_size[k];
                        done             = 1'b1;
                    end
                end
                if (!done) begin
                    if (pool_count >= SLOTS) removed += purge_aged();
                    if (pool_count >= SLOTS) begin
                        found = 1'b0;
                        best  = 0;
                        for (int unsigned k = 0; k < pool_count; k++) begin
                            if (!pool_busy[k] && (!found || pool_size[k] < pool_size[best])) begin
                                best  = k;
                                found = 1'b1;
                            end
                        end
                        if (found && pool_size[best] < need) begin
                            drop_slot(best);
                            removed++;
                        end else begin
                            res.status = ST_EXHAUSTED;
                            done       = 1'b1;
                        end
                    end
                end
                if (!done) begin
                    if (!it.alloc_ok) begin
                        res.status = ST_CREATE_ERR;
                    end else begin
                        pool_busy[pool_count]  = 1'b1;
                        pool_size[pool_count]  = need;
                        pool_stamp[pool_count] = pool_clock;
                        pool_ident[pool_count] = pool_next_id;
                        pool_count++;
                        res.status       = ST_CREATED;
                        res.granted_id   = pool_next_id;
                        res.granted_size = need;
                        pool_next_id     = pool_next_id + 16'd1;
                    end
                end
            end
            OP_RELEASE: begin
                res.status = ST_UNKNOWN_ID;
                // first match in table order wins on duplicate ids
                for (int unsigned k = 0; k < pool_count; k++) begin
                    if (pool_ident[k] == it.buf_id) begin
                        pool_busy[k]  = 1'b0;
                        pool_stamp[k] = pool_clock;
                        res.status    = ST_RELEASED;
                        break;
                    end
                end
            end
            OP_COLLECT: begin
                removed    = purge_aged();
                res.status = ST_COLLECTED;
            end
            OP_CLEAR: begin
                removed = pool_count;
                for (int k = 0; k < SLOTS; k++) pool_busy[k] = 1'b0;
                pool_count = 0;
                res.status = ST_CLEARED;
            end
            default: begin
                pool_clock = pool_clock + 32'd1;
                res.status = ST_TICKED;
            end
        endcase
        res.removed_count = (removed > 31) ? 5'd31 : removed[4:0];
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // result checker: oldest expectation first, field by field
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item %p", $time, m_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, m_data.status);
                    error_count++;
                end
                if (m_data.granted_id !== want.granted_id) begin
                    $display("%0t: granted_id expected %0d got %0d",
                             $time, want.granted_id, m_data.granted_id);
                    error_count++;
                end
                if (m_data.granted_size !== want.granted_size) begin
                    $display("%0t: granted_size expected %0h got %0h",
                             $time, want.granted_size, m_data.granted_size);
                    error_count++;
                end
                if (m_data.removed_count !== want.removed_count) begin
                    $display("%0t: removed_count expected %0d got %0d",
                             $time, want.removed_count, m_data.removed_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    int unsigned stuck_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender helpers
    // ---------------------------------------------------------------------
    // offer one item and hold it until taken; valid is left high
    task automatic offer(input in_item_t it, input bit typed, input out_item_t fixed);
        out_item_t res;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (pool_predict(it, res))
            pending_results = {pending_results, (typed ? fixed : res)};
    endtask

    task automatic idle_gap(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 11));
    endtask

    // all results home, then let any dropped item finish inside the block
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] min_sz, input logic [31:0] age);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_SIZE;
        cfg_data  <= min_sz;
        @(posedge aclk);
        cfg_index <= REG_MAX_AGE;
        cfg_data  <= age;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sh_min_size = min_sz;
        sh_max_age  = age;
    endtask

    function automatic in_item_t make_item(input logic [2:0] op, input logic [31:0] sz,
                                           input logic [15:0] id, input logic ok);
        in_item_t it;
        it.op       = op;
        it.req_size = sz;
        it.buf_id   = id;
        it.alloc_ok = ok;
        return it;
    endfunction

    function automatic out_item_t make_res(input status_t st, input logic [15:0] id,
                                           input logic [31:0] sz, input logic [4:0] rm);
        out_item_t r;
        r.status        = st;
        r.granted_id    = id;
        r.granted_size  = sz;
        r.removed_count = rm;
        return r;
    endfunction

    // random item, weighted towards acquire/release on live ids
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        it   = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.op = OP_ACQUIRE;
            case ($urandom_range(0, 3))
                0: it.req_size = $urandom_range(0, 200);
                1: it.req_size = $urandom_range(0, 5000);
                2: it.req_size = $urandom;
                default: it.req_size = '0;
            endcase
            it.alloc_ok = ($urandom_range(0, 7) != 0);
        end else if (pick < 65) begin
            it.op = OP_RELEASE;
            if (pool_count > 0 && $urandom_range(0, 3) != 0)
                it.buf_id = pool_ident[$urandom_range(0, pool_count - 1)];
        end else if (pick < 73) begin
            it.op = OP_COLLECT;
        end else if (pick < 76) begin
            it.op = OP_CLEAR;
        end else if (pick < 96) begin
            it.op = OP_TICK;
        end else begin
            it.op = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------------
    typedef struct {
        in_item_t  item;
        bit        typed;  // expectation typed in below, else from the shadow pool
        out_item_t fixed;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic void add_row(input in_item_t it, input bit typed, input out_item_t r);
        plan_row_t row;
        row.item  = it;
        row.typed = typed;
        row.fixed = r;
        plan = {plan, row};
    endfunction

    function automatic void build_plan();
        out_item_t none;
        none = '0;
        // after reset: min_size 65536, max_age 1000, empty table
        add_row(make_item(OP_TICK, 0, 0, 0), 1, make_res(ST_TICKED, 0, 0, 0));
        add_row(make_item(OP_RELEASE, 0, 16'd5, 0), 1, make_res(ST_UNKNOWN_ID, 0, 0, 0));
        add_row(make_item(OP_ACQUIRE, 0, 0, 1), 1,
                make_res(ST_CREATED, 16'd0, 32'd65536, 0));
        add_row(make_item(OP_ACQUIRE, 32'hFFFF_FFFF, 0, 0), 1,
                make_res(ST_CREATE_ERR, 0, 0, 0));
        add_row(make_item(OP_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 1), 1,
                make_res(ST_CREATED, 16'd1, 32'hFFFF_FFFF, 0));
        add_row(make_item(OP_RELEASE, 32'hFFFF_FFFF, 16'd0, 1), 1,
                make_res(ST_RELEASED, 0, 0, 0));
        // releasing an already free entry just refreshes it
        add_row(make_item(OP_RELEASE, 0, 16'd0, 0), 1, make_res(ST_RELEASED, 0, 0, 0));
        add_row(make_item(OP_ACQUIRE, 32'd100, 0, 1), 1,
                make_res(ST_REUSED, 16'd0, 32'd65536, 0));
        add_row(make_item(OP_COLLECT, 0, 0, 0), 1, make_res(ST_COLLECTED, 0, 0, 0));
        add_row(make_item(OP_RELEASE, 0, 16'hFFFF, 0), 1, make_res(ST_UNKNOWN_ID, 0, 0, 0));
        // undefined ops: taken, no result
        add_row(make_item(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 1), 1, none);
        add_row(make_item(3'd7, 0, 0, 0), 1, none);
        add_row(make_item(OP_CLEAR, 0, 0, 0), 1, make_res(ST_CLEARED, 0, 0, 5'd2));
        // fill the table, then hit exhaustion and eviction via the shadow pool
        for (int k = 0; k < SLOTS; k++)
            add_row(make_item(OP_ACQUIRE, 32'd65536 + k * 4096, 0, 1), 0, none);
        add_row(make_item(OP_ACQUIRE, 32'd1, 0, 1), 0, none);
        add_row(make_item(OP_RELEASE, 0, 16'd4, 0), 0, none);
        add_row(make_item(OP_ACQUIRE, 32'h0010_0000, 0, 1), 0, none);
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [31:0] phase_min [4];
        logic [31:0] phase_age [4];
        out_item_t   none;
        none         = '0;
        error_count  = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        shadow_reset();
        build_plan();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            offer(plan[i].item, plan[i].typed, plan[i].fixed);
            maybe_gap();
        end

        // register settings per random phase, extremes first
        phase_min[0] = 32'd1;          phase_age[0] = 32'd0;
        phase_min[1] = 32'hFFFF_FFFF;  phase_age[1] = 32'hFFFF_FFFF;
        phase_min[2] = $urandom_range(1, 5000);
        phase_age[2] = $urandom_range(0, 20);
        phase_min[3] = 32'd64;         phase_age[3] = 32'd3;

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_config(phase_min[ph], phase_age[ph]);
            quiet = (ph == 3);
            for (int n = 0; n < RAND_PER_PH; n++) begin
                // long receiver hold-off while items keep coming
                if (ph == 0 && n == 40) hold_request = 1'b1;
                // sender waits for the pool to answer everything
                if (ph == 2 && n == 75) begin
                    s_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge aclk);
                end
                offer(random_item(), 0, none);
                maybe_gap();
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* buffer_pool_manager.f */
src/bpm_pkg.sv
src/buffer_pool_manager.sv
tb/sv/tb_top.sv
